// ===== hdl/bchd_pkg.sv =====
// package for the button click and hold detector
// holds widths, event codes, register indexes, reset values and the config struct
// no dependencies
package bchd_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 2;
    localparam int EVENT_W = 2;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 2'd0,
        EV_CLICK     = 2'd1,
        EV_HOLD      = 2'd2,
        EV_LONG_HOLD = 2'd3
    } event_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_HOLD      = 2'd1,
        REG_LONG_HOLD = 2'd2
    } reg_index_t;

    localparam logic [CFG_W-1:0]  DEBOUNCE_RESET  = 16'd20;
    localparam logic [CFG_W-1:0]  HOLD_RESET      = 16'd1000;
    localparam logic [CFG_W-1:0]  LONG_HOLD_RESET = 16'd3000;
    localparam logic [TIME_W-1:0] STAMP_RESET     = '1;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] hold_ms;
        logic [CFG_W-1:0] long_hold_ms;
    } cfg_t;

endpackage

// ===== hdl/bchd_if.sv =====
// channel interfaces: sample input, event result and configuration write
// depends on bchd_pkg
interface bchd_sample_if
    import bchd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              button_level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output button_level, output now_ms, input ready);
    modport sink (input valid, input button_level, input now_ms, output ready);
endinterface

interface bchd_result_if
    import bchd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink (input valid, input event_code, output ready);
endinterface

interface bchd_cfg_if
    import bchd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [CFG_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bchd_cfg.sv =====
// configuration registers: debounce, hold and long-hold times
// depends on bchd_pkg and bchd_cfg_if
module bchd_cfg
    import bchd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bchd_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (reg_index_t'(cfg.index))
                REG_DEBOUNCE:  regs_next.debounce_ms  = cfg.data;
                REG_HOLD:      regs_next.hold_ms      = cfg.data;
                REG_LONG_HOLD: regs_next.long_hold_ms = cfg.data;
                default:       regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.debounce_ms  <= DEBOUNCE_RESET;
            regs_reg.hold_ms      <= HOLD_RESET;
            regs_reg.long_hold_ms <= LONG_HOLD_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== hdl/bchd_core.sv =====
// press, release and hold classification with its state registers
// depends on bchd_pkg; state advances on each step
module bchd_core
    import bchd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              level,
    input  logic [TIME_W-1:0] now,
    input  cfg_t              regs,
    output event_t            ev
);

    logic              last_level_reg, last_level_next;
    logic              down_seen_reg, down_seen_next;
    logic              up_seen_reg, up_seen_next;
    logic              ignore_release_reg, ignore_release_next;
    logic              hold_fired_reg, hold_fired_next;
    logic              long_fired_reg, long_fired_next;
    logic [TIME_W-1:0] press_stamp_reg, press_stamp_next;
    logic [TIME_W-1:0] release_stamp_reg, release_stamp_next;

    logic [TIME_W-1:0] since_release;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] held_for;
    logic              press_edge;
    logic              release_edge;
    logic              press_new;
    logic              hold_due;

    assign since_release = now - release_stamp_reg;
    assign since_press   = now - press_stamp_reg;
    assign press_edge    = level && !last_level_reg
                           && (since_release > TIME_W'(regs.debounce_ms));
    assign release_edge  = !level && last_level_reg
                           && (since_press > TIME_W'(regs.debounce_ms));
    assign press_new     = press_edge && !down_seen_reg;
    assign held_for      = press_new ? '0 : since_press;
    assign hold_due      = level && (held_for >= TIME_W'(regs.hold_ms));

    always_comb
    begin
        ev                  = EV_NONE;
        last_level_next     = level;
        down_seen_next      = down_seen_reg;
        up_seen_next        = up_seen_reg;
        ignore_release_next = ignore_release_reg;
        hold_fired_next     = hold_fired_reg;
        long_fired_next     = long_fired_reg;
        press_stamp_next    = press_stamp_reg;
        release_stamp_next  = release_stamp_reg;

        priority if (press_edge)
        begin
            up_seen_next = 1'b0;
            if (press_new)
            begin
                press_stamp_next    = now;
                ignore_release_next = 1'b0;
                hold_fired_next     = 1'b0;
                long_fired_next     = 1'b0;
                down_seen_next      = 1'b1;
            end
        end
        else if (release_edge)
        begin
            down_seen_next = 1'b0;
            if (!ignore_release_reg && !up_seen_reg)
            begin
                release_stamp_next  = now;
                ignore_release_next = 1'b1;
                up_seen_next        = 1'b1;
                ev                  = EV_CLICK;
            end
        end
        else
        begin
            down_seen_next = down_seen_reg;
        end

        if (hold_due)
        begin
            if (!hold_fired_next)
            begin
                ev                  = EV_HOLD;
                ignore_release_next = 1'b1;
                press_stamp_next    = now;
                hold_fired_next     = 1'b1;
            end
            // measured from the stamp as it stands after the hold test
            if (((now - press_stamp_next) >= TIME_W'(regs.long_hold_ms)) && !long_fired_next)
            begin
                ev              = EV_LONG_HOLD;
                long_fired_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg     <= 1'b0;
            down_seen_reg      <= 1'b0;
            up_seen_reg        <= 1'b0;
            ignore_release_reg <= 1'b0;
            hold_fired_reg     <= 1'b0;
            long_fired_reg     <= 1'b0;
            press_stamp_reg    <= STAMP_RESET;
            release_stamp_reg  <= STAMP_RESET;
        end
        else if (step)
        begin
            last_level_reg     <= last_level_next;
            down_seen_reg      <= down_seen_next;
            up_seen_reg        <= up_seen_next;
            ignore_release_reg <= ignore_release_next;
            hold_fired_reg     <= hold_fired_next;
            long_fired_reg     <= long_fired_next;
            press_stamp_reg    <= press_stamp_next;
            release_stamp_reg  <= release_stamp_next;
        end
    end

endmodule

// ===== hdl/button_click_hold_detector.sv =====
// top level of the button click and hold detector
// depends on bchd_pkg, the channel interfaces, bchd_cfg and bchd_core
//
//   channel  | dir | payload                    | request taken when
//   ---------+-----+----------------------------+---------------------
//   sample   | in  | button_level, now_ms       | valid && ready
//   result   | out | event_code                 | valid && ready
//   cfg      | in  | index, data                | valid && ready
//
// one request per cycle sustained while the result is not stalled
// stage one holds the sample, stage two the event code; state updates as
// a sample moves from stage one into the result register
// a stalled result holds its register and a full stage one; sample ready drops only then
// cfg is always ready; reset loads the default times, clears the valid and core flags and sets the stamps to all ones
module button_click_hold_detector
    import bchd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    bchd_sample_if.sink    sample,
    bchd_result_if.source  result,
    bchd_cfg_if.sink       cfg
);

    cfg_t              regs;
    event_t            ev;
    logic              stall;
    logic              advance;
    logic              s1_valid_reg;
    logic              s1_level_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              out_valid_reg;
    event_t            event_reg;

    assign stall        = out_valid_reg && !result.ready;
    assign advance      = s1_valid_reg && !stall;
    assign sample.ready = !s1_valid_reg || !stall;
    assign result.valid      = out_valid_reg;
    assign result.event_code = event_reg;

    bchd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    bchd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .level (s1_level_reg),
        .now   (s1_now_reg),
        .regs  (regs),
        .ev    (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (!stall)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_level_reg <= sample.button_level;
            s1_now_reg   <= sample.now_ms;
        end
        if (advance)
        begin
            event_reg <= ev;
        end
    end

endmodule

// ===== hdl/bchd_checker.sv =====
// port-level checks for the button click and hold detector, bound to the top
// depends on bchd_pkg and button_click_hold_detector
module bchd_checker
    import bchd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [EVENT_W-1:0] event_code,
    input logic               cfg_ready
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // a stalled result stays with the same code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code))
        else $error("result changed while stalled");

    // every request is followed by a valid result behind stage one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> ##1 out_valid)
        else $error("result missing after request");

    // a new result comes only from a request that passed through stage one
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_acc, 2))
        else $error("result without request");

    // sample side stalls only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("sample stalled without cause");

    // configuration never blocks
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg not ready");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .event_code (result.event_code),
    .cfg_ready  (cfg.ready)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for button_click_hold_detector
// a scoreboard class predicts one event code per accepted sample; tasks drive the channels
// depends on bchd_pkg, the channel interfaces and the detector rtl
module tb_top;
    import bchd_pkg::*;

    localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 80;
    localparam int NUM_PHASES = 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    class click_hold_scoreboard;
        logic [CFG_W-1:0]  debounce_ms;
        logic [CFG_W-1:0]  hold_ms;
        logic [CFG_W-1:0]  long_hold_ms;
        bit                prev_level;
        bit                down_seen;
        bit                up_seen;
        bit                ignore_release;
        bit                hold_fired;
        bit                long_fired;
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] release_stamp;
        event_t            expected_q[$];
        int                errors;

        function new();
            debounce_ms    = DEBOUNCE_RESET;
            hold_ms        = HOLD_RESET;
            long_hold_ms   = LONG_HOLD_RESET;
            prev_level     = 1'b0;
            down_seen      = 1'b0;
            up_seen        = 1'b0;
            ignore_release = 1'b0;
            hold_fired     = 1'b0;
            long_fired     = 1'b0;
            press_stamp    = STAMP_RESET;
            release_stamp  = STAMP_RESET;
            errors         = 0;
        endfunction

        function void write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_DEBOUNCE:  debounce_ms = val;
                REG_HOLD:      hold_ms = val;
                REG_LONG_HOLD: long_hold_ms = val;
                default:       ;
            endcase
        endfunction

        function void note_sample(bit lvl, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] since_release;
            logic [TIME_W-1:0] since_press;
            logic [TIME_W-1:0] db;
            event_t            ev;
            db = {16'd0, debounce_ms};
            ev = EV_NONE;
            since_release = now - release_stamp;
            since_press = now - press_stamp;
            if (lvl && !prev_level && since_release > db)
            begin
                up_seen = 1'b0;
                if (!down_seen)
                begin
                    press_stamp = now;
                    ignore_release = 1'b0;
                    hold_fired = 1'b0;
                    long_fired = 1'b0;
                    down_seen = 1'b1;
                end
            end
            else if (!lvl && prev_level && since_press > db)
            begin
                down_seen = 1'b0;
                if (!ignore_release && !up_seen)
                begin
                    release_stamp = now;
                    ignore_release = 1'b1;
                    up_seen = 1'b1;
                    ev = EV_CLICK;
                end
            end
            since_press = now - press_stamp;
            if (lvl && since_press >= {16'd0, hold_ms})
            begin
                if (!hold_fired)
                begin
                    ev = EV_HOLD;
                    ignore_release = 1'b1;
                    press_stamp = now;
                    hold_fired = 1'b1;
                end
                since_press = now - press_stamp;
                if (since_press >= {16'd0, long_hold_ms} && !long_fired)
                begin
                    ev = EV_LONG_HOLD;
                    long_fired = 1'b1;
                end
            end
            prev_level = lvl;
            expected_q.push_back(ev);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [EVENT_W-1:0] code);
            event_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("event_code %0d with no sample pending", code));
            end
            else
            begin
                want = expected_q.pop_front();
                if (code !== want)
                    report($sformatf("event_code got %0d want %0d", code, want));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bchd_sample_if smp();
    bchd_result_if res();
    bchd_cfg_if    cfgc();

    button_click_hold_detector u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfgc)
    );

    click_hold_scoreboard sb = new();

    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    int                hold_off_cycles = 0;
    int unsigned       cycle_count = 0;
    int unsigned       items_sent = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    always #4 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        smp.valid = 1'b0;
        smp.button_level = 1'b0;
        smp.now_ms = '0;
        res.ready = 1'b0;
        cfgc.valid = 1'b0;
        cfgc.index = '0;
        cfgc.data = '0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result checked before the same-edge sample is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
                sb.check_result(res.event_code);
            if (smp.valid && smp.ready)
                sb.note_sample(smp.button_level, smp.now_ms);
        end
    end

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            res.ready <= 1'b0;
            hold_off_cycles--;
        end
        else
        begin
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            smp.valid <= 1'b0;
            @(negedge clk);
        end
        smp.valid <= 1'b1;
        smp.button_level <= lvl;
        smp.now_ms <= t;
        do @(posedge clk); while (!smp.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic step(input logic lvl, input int unsigned delta);
        clock_ms = clock_ms + delta;
        send_sample(lvl, clock_ms);
    endtask

    task automatic write_cfg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfgc.valid <= 1'b1;
        cfgc.index <= idx;
        cfgc.data <= val;
        do @(posedge clk); while (!cfgc.ready);
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic set_timing(input cfg_t c);
        write_cfg(REG_DEBOUNCE, c.debounce_ms);
        write_cfg(REG_HOLD, c.hold_ms);
        write_cfg(REG_LONG_HOLD, c.long_hold_ms);
        write_cfg(REG_UNUSED, CFG_W'($urandom));
        cfgc.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        smp.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 71; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default:       begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
    endtask

    // low gap, optional bounce, then a press of a length picked around the thresholds
    task automatic press_sequence();
        int unsigned db;
        int unsigned hd;
        int unsigned lh;
        int unsigned dur;
        int unsigned k;
        db = sb.debounce_ms;
        hd = sb.hold_ms;
        lh = sb.long_hold_ms;
        step(1'b0, $urandom_range(2 * db + 2));
        if ($urandom_range(3) == 0)
        begin
            repeat ($urandom_range(3, 1))
            begin
                step(1'b1, $urandom_range(db));
                step(1'b0, $urandom_range(db));
            end
        end
        case ($urandom_range(3))
            0:       dur = $urandom_range(db + 1);
            1:       dur = $urandom_range(hd + db + 1, db);
            2:       dur = hd + $urandom_range(lh + 1);
            default: dur = hd + lh + $urandom_range(hd + 1);
        endcase
        k = $urandom_range(6, 1);
        step(1'b1, $urandom_range(3, 1));
        repeat (k)
            step(1'b1, dur / k + $urandom_range(2));
        step(1'b0, $urandom_range(2));
    endtask

    task automatic noise_item();
        int unsigned span;
        span = sb.debounce_ms + sb.hold_ms + 2;
        if ($urandom_range(15) == 0)
            step(1'($urandom_range(1)), $urandom);
        else
            step(1'($urandom_range(1)), $urandom_range(span));
    endtask

    task automatic directed_items();
        cfg_t c;
        // hold from the reset stamp, then long hold, release without click
        send_sample(1'b1, 32'd0);
        send_sample(1'b1, 32'd1500);
        send_sample(1'b1, 32'd4500);
        send_sample(1'b0, 32'd4510);
        // press, bounced release, repeated press, click, then a new press through hold and long hold
        send_sample(1'b1, 32'd4520);
        send_sample(1'b0, 32'd4530);
        send_sample(1'b1, 32'd4535);
        send_sample(1'b0, 32'd4600);
        send_sample(1'b1, 32'd4610);
        send_sample(1'b0, 32'd4620);
        send_sample(1'b1, 32'd4700);
        send_sample(1'b1, 32'd5700);
        send_sample(1'b1, 32'd8700);
        send_sample(1'b1, 32'd20000);
        send_sample(1'b0, 32'd20010);
        // click across the timestamp wrap
        send_sample(1'b0, 32'hFFFF_FFF0);
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'h0000_0020);
        // zero times: hold and long hold due together
        wait_idle();
        c = '{debounce_ms: 16'd0, hold_ms: 16'd0, long_hold_ms: 16'd0};
        set_timing(c);
        send_sample(1'b1, 32'd100);
        send_sample(1'b1, 32'd101);
        send_sample(1'b0, 32'd102);
        send_sample(1'b1, 32'd102);
        // largest times
        wait_idle();
        c = '{debounce_ms: 16'hFFFF, hold_ms: 16'hFFFF, long_hold_ms: 16'hFFFF};
        set_timing(c);
        send_sample(1'b0, 32'd200000);
        send_sample(1'b1, 32'd300000);
        send_sample(1'b1, 32'd365535);
        send_sample(1'b1, 32'd431070);
        send_sample(1'b0, 32'd431071);
        clock_ms = 32'd431071;
    endtask

    initial
    begin
        cfg_t        plan[NUM_PHASES];
        int unsigned start;
        bit          held;
        bit          paused;

        plan[0] = '{debounce_ms: 16'd5,     hold_ms: 16'd40,    long_hold_ms: 16'd80};
        plan[1] = '{debounce_ms: 16'd0,     hold_ms: 16'd0,     long_hold_ms: 16'd0};
        plan[2] = '{debounce_ms: 16'hFFFF,  hold_ms: 16'hFFFF,  long_hold_ms: 16'hFFFF};
        plan[3] = '{debounce_ms: 16'd2,     hold_ms: 16'd15,    long_hold_ms: 16'd0};
        plan[4] = '{debounce_ms: 16'd0,     hold_ms: 16'hFFFF,  long_hold_ms: 16'd3};
        plan[5] = '{debounce_ms: 16'hFFFF,  hold_ms: 16'd0,     long_hold_ms: 16'hFFFF};
        plan[6] = '{debounce_ms: CFG_W'($urandom_range(30)),
                    hold_ms: CFG_W'($urandom_range(200)),
                    long_hold_ms: CFG_W'($urandom_range(400))};
        plan[7] = '{debounce_ms: DEBOUNCE_RESET, hold_ms: HOLD_RESET,
                    long_hold_ms: LONG_HOLD_RESET};
        held = 1'b0;
        paused = 1'b0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_items();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            set_idling(idle_mode_t'(p % 4));
            set_timing(plan[p]);
            @(negedge clk);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                // long receiver hold-off while samples keep coming
                if (p == 0 && !held && items_sent - start >= 20)
                begin
                    hold_off_cycles = 50;
                    held = 1'b1;
                end
                if (p == 3 && !paused && items_sent - start >= 40)
                begin
                    smp.valid <= 1'b0;
                    while (sb.pending() != 0)
                        @(negedge clk);
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 80)
                    press_sequence();
                else
                    noise_item();
            end
        end

        smp.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
